// ===== hdl/arpc_pkg.sv =====
`timescale 1ns / 1ps

package arpc_pkg;

  // default cache depth
  localparam int unsigned CacheEntriesDef = 16;

  // item operation codes
  localparam logic [1:0] OP_LEARN   = 2'd0;
  localparam logic [1:0] OP_RESOLVE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;
  localparam logic [1:0] OP_UNDEF   = 2'd3;  // spare code, answered as invalid

  // result status codes
  localparam logic [3:0] ST_SHORT    = 4'd0;
  localparam logic [3:0] ST_INVALID  = 4'd1;
  localparam logic [3:0] ST_UPDATED  = 4'd2;
  localparam logic [3:0] ST_ADDED    = 4'd3;
  localparam logic [3:0] ST_REPLACED = 4'd4;
  localparam logic [3:0] ST_OWN      = 4'd5;
  localparam logic [3:0] ST_HIT      = 4'd6;
  localparam logic [3:0] ST_MISS     = 4'd7;
  localparam logic [3:0] ST_CLEARED  = 4'd8;

  // configuration register indexes
  localparam logic REG_OWN_IP  = 1'b0;
  localparam logic REG_OWN_MAC = 1'b1;

  // ARP header checks
  localparam logic [15:0] MinFrameLen   = 16'd42;
  localparam logic [15:0] HtypeEthernet = 16'd1;
  localparam logic [15:0] PtypeIpv4     = 16'h0800;
  localparam logic [7:0]  HlenEthernet  = 8'd6;
  localparam logic [7:0]  PlenIpv4      = 8'd4;
  localparam logic [15:0] OpcodeRequest = 16'd1;
  localparam logic [15:0] OpcodeReply   = 16'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] frame_length;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hardware_len;
    logic [7:0]  protocol_len;
    logic [15:0] arp_opcode;
    logic [31:0] src_ip;
    logic [47:0] src_mac;
    logic [31:0] dst_ip;
    logic [31:0] query_ip;
  } item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        send_reply;
    logic [47:0] reply_mac;
    logic [31:0] reply_ip;
    logic [47:0] resolved_mac;
  } result_t;

  // sequencer to entry store controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } store_ctrl_t;

endpackage

// ===== hdl/arp_cache_and_responder.sv =====
`timescale 1ns / 1ps

// Channel  | Ports                                | Handshake
// ---------+--------------------------------------+-------------------------------
// item     | start_i, busy_o, item_i              | taken when start_i & !busy_o
// result   | done_o, result_o                     | valid for the one cycle done_o
// config   | cfg_we_i, cfg_idx_i, cfg_wdata_i     | written when cfg_we_i is high
//
// An item is answered straight from S_CHECK when decided from the header or
// own address alone (reject, clear, own hit); otherwise S_SCAN walks the
// entry store, one entry a cycle through its single read port.
// busy_o stays high until the cycle after the strobe. Reset clears the valid
// bits and the own address registers at once; no clearing pass is needed.
// The receiver cannot stall: each result is shown for exactly one cycle.

module arp_cache_and_responder #(
  parameter int unsigned CACHE_ENTRIES = arpc_pkg::CacheEntriesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  arpc_pkg::item_t   item_i,
  output logic              done_o,
  output arpc_pkg::result_t result_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [47:0]       cfg_wdata_i
);

  localparam int unsigned IdxW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  logic [31:0]           own_ip_q;
  logic [47:0]           own_mac_q;
  arpc_pkg::store_ctrl_t ctrl;
  logic [IdxW-1:0]       rd_addr, wr_addr;
  logic [31:0]           wr_ip, rd_ip;
  logic [47:0]           wr_mac, rd_mac;
  logic                  rd_valid;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q  <= '0;
      own_mac_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        arpc_pkg::REG_OWN_IP:  own_ip_q  <= cfg_wdata_i[31:0];
        arpc_pkg::REG_OWN_MAC: own_mac_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  arpc_seq #(
    .Entries (CACHE_ENTRIES),
    .IdxW    (IdxW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .own_ip_i   (own_ip_q),
    .own_mac_i  (own_mac_q),
    .ctrl_o     (ctrl),
    .rd_addr_o  (rd_addr),
    .wr_addr_o  (wr_addr),
    .wr_ip_o    (wr_ip),
    .wr_mac_o   (wr_mac),
    .rd_valid_i (rd_valid),
    .rd_ip_i    (rd_ip),
    .rd_mac_i   (rd_mac)
  );

  arpc_store #(
    .Entries (CACHE_ENTRIES),
    .IdxW    (IdxW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .wr_ip_i    (wr_ip),
    .wr_mac_i   (wr_mac),
    .rd_valid_o (rd_valid),
    .rd_ip_o    (rd_ip),
    .rd_mac_o   (rd_mac)
  );

endmodule

// ===== hdl/arpc_store.sv =====
`timescale 1ns / 1ps

module arpc_store #(
  parameter int unsigned Entries = arpc_pkg::CacheEntriesDef,
  parameter int unsigned IdxW    = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  arpc_pkg::store_ctrl_t ctrl_i,
  input  logic [IdxW-1:0]       rd_addr_i,
  input  logic [IdxW-1:0]       wr_addr_i,
  input  logic [31:0]           wr_ip_i,
  input  logic [47:0]           wr_mac_i,
  output logic                  rd_valid_o,
  output logic [31:0]           rd_ip_o,
  output logic [47:0]           rd_mac_o
);

  logic [31:0]  ip_mem  [Entries];
  logic [47:0]  mac_mem [Entries];
  logic [Entries-1:0] valid_q;
  logic         rd_valid_q;
  logic [31:0]  rd_ip_q;
  logic [47:0]  rd_mac_q;

  // entry valid bits, cleared at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.clr) begin
        valid_q <= '0;
      end else if (ctrl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // address and MAC memory, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      ip_mem[wr_addr_i]  <= wr_ip_i;
      mac_mem[wr_addr_i] <= wr_mac_i;
    end
    if (ctrl_i.rd_en) begin
      rd_ip_q  <= ip_mem[rd_addr_i];
      rd_mac_q <= mac_mem[rd_addr_i];
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_ip_o    = rd_ip_q;
  assign rd_mac_o   = rd_mac_q;

endmodule

// ===== hdl/arpc_seq.sv =====
`timescale 1ns / 1ps

module arpc_seq #(
  parameter int unsigned Entries = arpc_pkg::CacheEntriesDef,
  parameter int unsigned IdxW    = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  arpc_pkg::item_t       item_i,
  output logic                  done_o,
  output arpc_pkg::result_t     result_o,
  input  logic [31:0]           own_ip_i,
  input  logic [47:0]           own_mac_i,
  output arpc_pkg::store_ctrl_t ctrl_o,
  output logic [IdxW-1:0]       rd_addr_o,
  output logic [IdxW-1:0]       wr_addr_o,
  output logic [31:0]           wr_ip_o,
  output logic [47:0]           wr_mac_o,
  input  logic                  rd_valid_i,
  input  logic [31:0]           rd_ip_i,
  input  logic [47:0]           rd_mac_i
);

  localparam logic [IdxW:0]   NumEntries = (IdxW + 1)'(Entries);
  localparam logic [IdxW-1:0] LastIdx    = IdxW'(Entries - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_SCAN  = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  arpc_pkg::item_t   item_q;
  arpc_pkg::result_t result_q, result_d;
  logic [IdxW:0]     cnt_q, cnt_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]   cmp_idx_q, cmp_idx_d;
  logic              free_found_q, free_found_d;
  logic [IdxW-1:0]   free_idx_q, free_idx_d;
  logic [IdxW-1:0]   tgt_q, tgt_d;

  logic        accept;
  logic [31:0] cmp_a, cmp_b;
  logic        cmp_eq;
  logic        hdr_short, hdr_bad;
  logic        hit;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;
  assign done_o = (state_q == S_DONE);
  assign result_o = result_q;

  // shared 32-bit compare: own address check, then one entry a cycle
  always_comb begin
    if (state_q == S_CHECK) begin
      cmp_a = (item_q.op == arpc_pkg::OP_RESOLVE) ? item_q.query_ip : item_q.dst_ip;
      cmp_b = own_ip_i;
    end else begin
      cmp_a = (item_q.op == arpc_pkg::OP_LEARN) ? item_q.src_ip : item_q.query_ip;
      cmp_b = rd_ip_i;
    end
  end
  assign cmp_eq = (cmp_a == cmp_b);
  assign hit    = rd_valid_i && cmp_eq;

  // header checks on the held word
  assign hdr_short = (item_q.frame_length < arpc_pkg::MinFrameLen);
  assign hdr_bad   = (item_q.hw_type != arpc_pkg::HtypeEthernet) ||
                     (item_q.proto_type != arpc_pkg::PtypeIpv4) ||
                     (item_q.hardware_len != arpc_pkg::HlenEthernet) ||
                     (item_q.protocol_len != arpc_pkg::PlenIpv4);

  // store write data comes straight from the held word
  assign wr_addr_o = tgt_q;
  assign wr_ip_o   = item_q.src_ip;
  assign wr_mac_o  = item_q.src_mac;

  // sequencer
  always_comb begin
    state_d      = state_q;
    result_d     = result_q;
    cnt_d        = cnt_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    tgt_d        = tgt_q;
    ctrl_o       = '0;
    rd_addr_o    = cnt_q[IdxW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        result_d     = '0;
        cnt_d        = '0;
        free_found_d = 1'b0;
        state_d      = S_DONE;
        case (item_q.op)
          arpc_pkg::OP_LEARN: begin
            if (hdr_short) begin
              result_d.status = arpc_pkg::ST_SHORT;
            end else if (hdr_bad) begin
              result_d.status = arpc_pkg::ST_INVALID;
            end else begin
              if ((item_q.arp_opcode == arpc_pkg::OpcodeRequest) && cmp_eq) begin
                result_d.send_reply = 1'b1;
                result_d.reply_mac  = item_q.src_mac;
                result_d.reply_ip   = item_q.src_ip;
              end
              state_d = S_SCAN;
            end
          end
          arpc_pkg::OP_RESOLVE: begin
            if (cmp_eq) begin
              result_d.status       = arpc_pkg::ST_OWN;
              result_d.resolved_mac = own_mac_i;
            end else begin
              state_d = S_SCAN;
            end
          end
          arpc_pkg::OP_CLEAR: begin
            ctrl_o.clr      = 1'b1;
            result_d.status = arpc_pkg::ST_CLEARED;
          end
          default: begin
            result_d.status = arpc_pkg::ST_INVALID;
          end
        endcase
      end

      S_SCAN: begin
        // issue the next read while the previous entry is compared
        if (cnt_q < NumEntries) begin
          ctrl_o.rd_en = 1'b1;
          cnt_d        = cnt_q + 1'b1;
          cmp_vld_d    = 1'b1;
          cmp_idx_d    = cnt_q[IdxW-1:0];
        end
        if (cmp_vld_q) begin
          if (hit) begin
            cmp_vld_d = 1'b0;
            if (item_q.op == arpc_pkg::OP_LEARN) begin
              tgt_d           = cmp_idx_q;
              result_d.status = arpc_pkg::ST_UPDATED;
              state_d         = S_WRITE;
            end else begin
              result_d.status       = arpc_pkg::ST_HIT;
              result_d.resolved_mac = rd_mac_i;
              state_d               = S_DONE;
            end
          end else begin
            if (!rd_valid_i && !free_found_q) begin
              free_found_d = 1'b1;
              free_idx_d   = cmp_idx_q;
            end
            if (cmp_idx_q == LastIdx) begin
              cmp_vld_d = 1'b0;
              if (item_q.op == arpc_pkg::OP_LEARN) begin
                state_d = S_WRITE;
                if (free_found_q) begin
                  tgt_d           = free_idx_q;
                  result_d.status = arpc_pkg::ST_ADDED;
                end else if (!rd_valid_i) begin
                  tgt_d           = cmp_idx_q;
                  result_d.status = arpc_pkg::ST_ADDED;
                end else begin
                  tgt_d           = '0;
                  result_d.status = arpc_pkg::ST_REPLACED;
                end
              end else begin
                result_d.status = arpc_pkg::ST_MISS;
                state_d         = S_DONE;
              end
            end
          end
        end
      end

      S_WRITE: begin
        ctrl_o.wr_en = 1'b1;
        state_d      = S_DONE;
      end

      S_DONE: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      cmp_vld_q    <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      cmp_vld_q    <= cmp_vld_d;
      free_found_q <= free_found_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    result_q   <= result_d;
    cmp_idx_q  <= cmp_idx_d;
    free_idx_q <= free_idx_d;
    tgt_q      <= tgt_d;
  end

  // checks
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("word accepted but block not busy");

  a_reply_on_learn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_q.send_reply) |->
      (result_q.status == arpc_pkg::ST_UPDATED || result_q.status == arpc_pkg::ST_ADDED ||
       result_q.status == arpc_pkg::ST_REPLACED))
    else $error("reply flagged without a stored sender pair");

  a_write_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.wr_en |=> done_o)
    else $error("entry write not followed by result");

  a_no_read_while_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.rd_en |-> (state_q == S_SCAN && !ctrl_o.wr_en && !ctrl_o.clr))
    else $error("store read outside the scan");

endmodule

// ===== bench/arp_cache_and_responder_test.sv =====
`timescale 1ns / 1ps

module arp_cache_and_responder_test;
  import arpc_pkg::*;

  localparam int Depth         = CacheEntriesDef;
  localparam int WatchdogLimit = 2000;
  localparam int TailCycles    = Depth + 8;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start_i     = 1'b0;
  logic        busy_o;
  item_t       item_i      = '0;
  logic        done_o;
  result_t     result_o;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_idx_i   = REG_OWN_IP;
  logic [47:0] cfg_wdata_i = '0;

  arp_cache_and_responder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // items still to be sent, answers still due
  item_t       arp_items[$];
  result_t     due_answers[$];
  int          n_issued        = 0;
  int          n_taken         = 0;
  int          errors          = 0;
  int          quiet_cycles    = 0;
  int          sender_idle_pct = 0;
  logic [31:0] ip_pool[$];

  // our own view of the station and its cache
  logic [31:0] our_ip  = '0;
  logic [47:0] our_mac = '0;
  logic        cache_valid [Depth] = '{default: 1'b0};
  logic [31:0] cache_ip    [Depth];
  logic [47:0] cache_mac   [Depth];

  function automatic int cache_lookup(logic [31:0] ip);
    for (int i = 0; i < Depth; i++) begin
      if (cache_valid[i] && cache_ip[i] == ip) return i;
    end
    return -1;
  endfunction

  // expected answer to one item; updates the cache copy
  function automatic result_t arp_outcome(item_t it);
    result_t r;
    int      slot;
    r        = '0;
    r.status = ST_INVALID;
    case (it.op)
      OP_LEARN: begin
        if (it.frame_length < MinFrameLen) begin
          r.status = ST_SHORT;
        end else if (it.hw_type != HtypeEthernet || it.proto_type != PtypeIpv4 ||
                     it.hardware_len != HlenEthernet || it.protocol_len != PlenIpv4) begin
          r.status = ST_INVALID;
        end else begin
          slot = cache_lookup(it.src_ip);
          if (slot >= 0) begin
            cache_mac[slot] = it.src_mac;
            r.status        = ST_UPDATED;
          end else begin
            // lowest free entry, else entry 0 is overwritten
            for (int i = Depth - 1; i >= 0; i--) begin
              if (!cache_valid[i]) slot = i;
            end
            if (slot >= 0) begin
              r.status = ST_ADDED;
            end else begin
              slot     = 0;
              r.status = ST_REPLACED;
            end
            cache_ip[slot]    = it.src_ip;
            cache_mac[slot]   = it.src_mac;
            cache_valid[slot] = 1'b1;
          end
          if (it.arp_opcode == OpcodeRequest && it.dst_ip == our_ip) begin
            r.send_reply = 1'b1;
            r.reply_mac  = it.src_mac;
            r.reply_ip   = it.src_ip;
          end
        end
      end
      OP_RESOLVE: begin
        if (it.query_ip == our_ip) begin
          r.status       = ST_OWN;
          r.resolved_mac = our_mac;
        end else begin
          slot = cache_lookup(it.query_ip);
          if (slot >= 0) begin
            r.status       = ST_HIT;
            r.resolved_mac = cache_mac[slot];
          end else begin
            r.status = ST_MISS;
          end
        end
      end
      OP_CLEAR: begin
        foreach (cache_valid[i]) cache_valid[i] = 1'b0;
        r.status = ST_CLEARED;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [47:0] rand_mac();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  function automatic item_t noise_item();
    item_t it;
    it.op           = 2'($urandom_range(3, 0));
    it.frame_length = 16'($urandom_range(16'hFFFF, 0));
    it.hw_type      = 16'($urandom_range(16'hFFFF, 0));
    it.proto_type   = 16'($urandom_range(16'hFFFF, 0));
    it.hardware_len = 8'($urandom_range(8'hFF, 0));
    it.protocol_len = 8'($urandom_range(8'hFF, 0));
    it.arp_opcode   = 16'($urandom_range(16'hFFFF, 0));
    it.src_ip       = $urandom;
    it.src_mac      = rand_mac();
    it.dst_ip       = $urandom;
    it.query_ip     = $urandom;
    return it;
  endfunction

  // well-formed learn word, spare fields random
  function automatic item_t learn_of(logic [15:0] opcode, logic [31:0] sip,
                                     logic [47:0] smac, logic [31:0] tip);
    item_t it;
    it              = noise_item();
    it.op           = OP_LEARN;
    it.frame_length = 16'($urandom_range(1518, MinFrameLen));
    it.hw_type      = HtypeEthernet;
    it.proto_type   = PtypeIpv4;
    it.hardware_len = HlenEthernet;
    it.protocol_len = PlenIpv4;
    it.arp_opcode   = opcode;
    it.src_ip       = sip;
    it.src_mac      = smac;
    it.dst_ip       = tip;
    return it;
  endfunction

  function automatic item_t query_of(logic [31:0] q);
    item_t it;
    it          = noise_item();
    it.op       = OP_RESOLVE;
    it.query_ip = q;
    return it;
  endfunction

  function automatic logic [31:0] pool_ip();
    return ip_pool[$urandom_range(ip_pool.size() - 1, 0)];
  endfunction

  // mostly well-formed traffic over a small address pool so the cache fills
  function automatic item_t random_item();
    item_t       it;
    int          pick;
    logic [15:0] opcode;
    logic [31:0] sip;
    logic [31:0] tip;
    pick = $urandom_range(99, 0);
    if (pick < 55) begin
      case ($urandom_range(9, 0))
        0, 1, 2, 3, 4: opcode = OpcodeRequest;
        5, 6, 7:       opcode = OpcodeReply;
        default:       opcode = 16'($urandom_range(16'hFFFF, 0));
      endcase
      sip = ($urandom_range(9, 0) != 0) ? pool_ip() : $urandom;
      case ($urandom_range(4, 0))
        0, 1:    tip = our_ip;
        2:       tip = $urandom;
        default: tip = pool_ip();
      endcase
      it = learn_of(opcode, sip, rand_mac(), tip);
      if ($urandom_range(4, 0) == 0)
        it.frame_length = 16'($urandom_range(16'hFFFF, MinFrameLen));
    end else if (pick < 80) begin
      case ($urandom_range(9, 0))
        0:       it = query_of(our_ip);
        1, 2:    it = query_of($urandom);
        default: it = query_of(pool_ip());
      endcase
    end else if (pick < 81) begin
      it    = noise_item();
      it.op = OP_CLEAR;
    end else if (pick < 84) begin
      it    = noise_item();
      it.op = OP_UNDEF;
    end else if (pick < 92) begin
      // one header check broken
      it = learn_of(OpcodeRequest, pool_ip(), rand_mac(), our_ip);
      case ($urandom_range(4, 0))
        0:       it.frame_length = 16'($urandom_range(MinFrameLen - 1, 0));
        1:       it.hw_type      = 16'($urandom_range(16'hFFFF, 0));
        2:       it.proto_type   = 16'($urandom_range(16'hFFFF, 0));
        3:       it.hardware_len = 8'($urandom_range(8'hFF, 0));
        default: it.protocol_len = 8'($urandom_range(8'hFF, 0));
      endcase
    end else begin
      it = noise_item();
    end
    return it;
  endfunction

  task automatic check_field(string field, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      errors++;
    end
  endtask

  // command driver: hold a word until taken, idle at random between words
  always @(negedge clk_i) begin
    if (rst_ni && n_taken == n_issued) begin
      if (arp_items.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
        start_i <= 1'b1;
        item_i  <= arp_items.pop_front();
        n_issued++;
      end else begin
        start_i <= 1'b0;
        item_i  <= noise_item();
      end
    end
  end

  // monitor: register writes, result words, accepted items
  always @(posedge clk_i) begin : mon
    result_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_OWN_IP:  our_ip  = cfg_wdata_i[31:0];
          REG_OWN_MAC: our_mac = cfg_wdata_i;
          default: ;
        endcase
      end
      if (done_o) begin
        if (due_answers.size() == 0) begin
          $error("result word with no answer due, status 0x%0h", result_o.status);
          errors++;
        end else begin
          want = due_answers.pop_front();
          check_field("status", 48'(want.status), 48'(result_o.status));
          check_field("send_reply", 48'(want.send_reply), 48'(result_o.send_reply));
          check_field("reply_mac", want.reply_mac, result_o.reply_mac);
          check_field("reply_ip", 48'(want.reply_ip), 48'(result_o.reply_ip));
          check_field("resolved_mac", want.resolved_mac, result_o.resolved_mac);
        end
      end
      if (start_i && !busy_o) begin
        due_answers.push_back(arp_outcome(item_i));
        n_taken++;
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk_i) begin
    if (done_o || (start_i && !busy_o)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("[arp_cache_and_responder] ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [47:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // wait for every word to be sent and answered, then let the block go idle
  task automatic settle();
    while (arp_items.size() != 0 || n_taken != n_issued || due_answers.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [31:0] ip, logic [47:0] mac, int idle, int count,
                           bit directed);
    item_t it;
    settle();
    write_reg(REG_OWN_IP, {16'h0, ip});
    write_reg(REG_OWN_MAC, mac);
    @(posedge clk_i);
    sender_idle_pct = idle;
    ip_pool.delete();
    ip_pool.push_back(ip);
    repeat (19) ip_pool.push_back($urandom);
    if (directed) begin
      arp_items.push_back(query_of(ip));                          // own address
      arp_items.push_back(query_of(32'h0));                       // miss on empty cache
      it = learn_of(OpcodeReply, 32'h0A00_0005, 48'h1111_2222_3333, 32'h0A00_0009);
      it.frame_length = 16'd0;                                    // too short
      arp_items.push_back(it);
      it.frame_length = MinFrameLen - 16'd1;
      arp_items.push_back(it);
      it.frame_length = MinFrameLen;                              // shortest accepted
      arp_items.push_back(it);
      it.frame_length = 16'hFFFF;                                 // same sender, update
      it.src_mac      = 48'h4444_5555_6666;
      arp_items.push_back(it);
      it = learn_of(OpcodeRequest, 32'h0A00_0006, rand_mac(), ip);
      it.hw_type = 16'd0;                                         // bad header fields
      arp_items.push_back(it);
      it.hw_type    = HtypeEthernet;
      it.proto_type = 16'h0806;
      arp_items.push_back(it);
      it.proto_type   = PtypeIpv4;
      it.hardware_len = 8'd5;
      arp_items.push_back(it);
      it.hardware_len = HlenEthernet;
      it.protocol_len = 8'd16;
      arp_items.push_back(it);
      it.protocol_len = PlenIpv4;                                 // request to us: reply
      arp_items.push_back(it);
      arp_items.push_back(learn_of(OpcodeReply, 32'h0A00_0007, rand_mac(), ip));
      arp_items.push_back(learn_of(16'hFFFF, 32'h0A00_0008, rand_mac(), ip));
      arp_items.push_back(learn_of(16'd0, ip, rand_mac(), 32'h0A00_0001)); // our own pair
      arp_items.push_back(query_of(32'h0A00_0005));               // hit
      arp_items.push_back(query_of(ip));                          // own beats cache
      arp_items.push_back(query_of(32'hFFFF_FFFF));
      it    = noise_item();
      it.op = OP_UNDEF;                                           // undefined op
      arp_items.push_back(it);
      arp_items.push_back(learn_of(OpcodeRequest, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, ip));
      arp_items.push_back(learn_of(OpcodeRequest, 32'h0, 48'h0, ip));
      it    = noise_item();
      it.op = OP_CLEAR;
      arp_items.push_back(it);
      arp_items.push_back(query_of(32'h0A00_0005));               // gone after clear
      arp_items.push_back(learn_of(OpcodeRequest, 32'h0A00_0005, rand_mac(), ~ip));
    end
    repeat (count) arp_items.push_back(random_item());
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    run_phase(32'hC0A8_0001, 48'h0200_5E10_2030, 12, 200, 1'b1);
    run_phase(32'h0, 48'h0, 12, 150, 1'b0);
    run_phase(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 85, 150, 1'b0);
    run_phase($urandom, rand_mac(), 85, 150, 1'b0);
    run_phase($urandom, rand_mac(), 0, 200, 1'b0);
    run_phase(32'h0000_0001, rand_mac(), 0, 180, 1'b0);
    settle();
    if (errors == 0) $display("[arp_cache_and_responder] OK");
    else $display("[arp_cache_and_responder] ERROR");
    $finish;
  end

endmodule

// ===== arp_cache_and_responder.f =====
hdl/arpc_pkg.sv
hdl/arpc_store.sv
hdl/arpc_seq.sv
hdl/arp_cache_and_responder.sv
bench/arp_cache_and_responder_test.sv
